// ===== rtl/fpp_pkg.sv =====
// fpp_pkg: shared widths, register indexes, defaults and the job record
// passed from the sample front end to the divide back end
// no dependencies
package fpp_pkg;

	localparam int SAMPLE_W    = 14;
	localparam int IDX_W       = 10;
	localparam int PAIR_W      = SAMPLE_W + 1;
	// window sums are kept wide enough for any mix of settings inside one waveform
	localparam int SUM_W       = SAMPLE_W + IDX_W;
	localparam int K_W         = 5;
	localparam int DVD_W       = SUM_W + 4;
	localparam int CNT_W       = $clog2(DVD_W);
	localparam int HALF_W      = IDX_W + 1;
	localparam int TIME_W      = HALF_W + 8;
	localparam int LIMIT_W     = 11;
	localparam int DIFF_W      = DVD_W + 1;
	localparam int PED_W       = 18;
	localparam int HGT_W       = 19;

	localparam int CNT_REG_W   = 11;
	localparam int PED_REG_W   = 6;
	localparam int PER_REG_W   = 8;
	localparam int CFG_DATA_W  = 11;
	localparam int CFG_IDX_W   = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PED_COUNT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PER   = 2'd2;

	localparam logic [CNT_REG_W-1:0] SAMPLE_COUNT_RST = 11'd48;
	localparam logic [PED_REG_W-1:0] PED_COUNT_RST    = 6'd10;
	localparam logic [PER_REG_W-1:0] SAMPLE_PER_RST   = 8'd8;

	localparam logic [CNT_REG_W-1:0] MIN_SAMPLES = 11'd4;
	localparam logic [CNT_REG_W-1:0] MAX_SAMPLES = 11'd1024;
	localparam logic [PED_REG_W-1:0] MAX_WINDOW  = 6'd31;
	localparam logic [LIMIT_W-1:0]   LIMIT_OFS   = 11'd100;

	typedef struct packed {
		logic [PAIR_W-1:0]    best_sum;
		logic [IDX_W-1:0]     best_idx;
		logic [SUM_W-1:0]     head_sum;
		logic [SUM_W-1:0]     tail_sum;
		logic [PED_REG_W-1:0] ped_count;
		logic [PER_REG_W-1:0] period;
		logic [K_W-1:0]       k;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_DONE = 3'b100
	} back_state_t;

endpackage

// ===== rtl/fpp_front.sv =====
// fpp_front: per-sample peak pair search and pedestal window sums
// depends on fpp_pkg
module fpp_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [fpp_pkg::CNT_REG_W-1:0]    sample_count,
	input  logic [fpp_pkg::PED_REG_W-1:0]    ped_count,
	input  logic [fpp_pkg::PER_REG_W-1:0]    sample_period_ns,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [fpp_pkg::SAMPLE_W-1:0]     sample,
	input  logic                             q_full,
	output logic                             push,
	output fpp_pkg::job_t                    job
);

	logic [fpp_pkg::IDX_W-1:0]     idx_q;
	logic [fpp_pkg::SAMPLE_W-1:0]  prev_q;
	logic [fpp_pkg::PAIR_W-1:0]    best_sum_q, best_sum_nx;
	logic [fpp_pkg::IDX_W-1:0]     best_idx_q, best_idx_nx;
	logic [fpp_pkg::SUM_W-1:0]     head_q, head_nx, tail_q, tail_nx;

	logic [fpp_pkg::CNT_REG_W-1:0] n_eff, n_m1, idx_ext, tail_start;
	logic [fpp_pkg::PED_REG_W-1:0] k6;
	logic [fpp_pkg::K_W-1:0]       k;
	logic [fpp_pkg::PAIR_W-1:0]    pair_sum;
	logic                          is_last, accept;

	// effective sample count and window size
	always_comb begin
		if (sample_count < fpp_pkg::MIN_SAMPLES) begin
			n_eff = fpp_pkg::MIN_SAMPLES;
		end else if (sample_count > fpp_pkg::MAX_SAMPLES) begin
			n_eff = fpp_pkg::MAX_SAMPLES;
		end else begin
			n_eff = sample_count;
		end
		n_m1 = n_eff - 11'd1;
		k6 = (ped_count != '0) ? ped_count - 6'd1 : '0;
		if (k6 > fpp_pkg::MAX_WINDOW) begin
			k6 = fpp_pkg::MAX_WINDOW;
		end
		if ({5'd0, k6} > n_m1) begin
			k6 = n_m1[fpp_pkg::PED_REG_W-1:0];
		end
		if (k6 == '0) begin
			k6 = 6'd1;
		end
		k = k6[fpp_pkg::K_W-1:0];
	end

	assign idx_ext    = {1'b0, idx_q};
	assign tail_start = n_eff - {6'd0, k};
	assign is_last    = (idx_ext + 11'd1) >= n_eff;
	assign in_stall   = is_last && q_full;
	assign accept     = in_valid && !in_stall;
	assign pair_sum   = {1'b0, prev_q} + {1'b0, sample};

	always_comb begin
		best_sum_nx = best_sum_q;
		best_idx_nx = best_idx_q;
		head_nx     = head_q;
		tail_nx     = tail_q;
		// later pair wins a tie
		if (idx_q >= 10'd2 && best_sum_q <= pair_sum) begin
			best_sum_nx = pair_sum;
			best_idx_nx = idx_q - 10'd1;
		end
		if (idx_q != '0 && idx_ext <= {6'd0, k}) begin
			head_nx = head_q + {{(fpp_pkg::SUM_W-fpp_pkg::SAMPLE_W){1'b0}}, sample};
		end
		if (idx_ext >= tail_start) begin
			tail_nx = tail_q + {{(fpp_pkg::SUM_W-fpp_pkg::SAMPLE_W){1'b0}}, sample};
		end
	end

	assign push          = accept && is_last;
	assign job.best_sum  = best_sum_nx;
	assign job.best_idx  = best_idx_nx;
	assign job.head_sum  = head_nx;
	assign job.tail_sum  = tail_nx;
	assign job.ped_count = ped_count;
	assign job.period    = sample_period_ns;
	assign job.k         = k;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			prev_q     <= '0;
			best_sum_q <= '0;
			best_idx_q <= 10'd1;
			head_q     <= '0;
			tail_q     <= '0;
		end else if (accept) begin
			if (is_last) begin
				idx_q      <= '0;
				prev_q     <= '0;
				best_sum_q <= '0;
				best_idx_q <= 10'd1;
				head_q     <= '0;
				tail_q     <= '0;
			end else begin
				idx_q      <= idx_q + 10'd1;
				prev_q     <= sample;
				best_sum_q <= best_sum_nx;
				best_idx_q <= best_idx_nx;
				head_q     <= head_nx;
				tail_q     <= tail_nx;
			end
		end
	end

endmodule

// ===== rtl/fpp_queue.sv =====
// fpp_queue: two-entry job queue between front end and back end
// depends on fpp_pkg
module fpp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  fpp_pkg::job_t push_job,
	input  logic          pop,
	output fpp_pkg::job_t pop_job,
	output logic          full,
	output logic          empty
);

	fpp_pkg::job_t entry_q [2];
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    count_q;

	assign full    = count_q == 2'd2;
	assign empty   = count_q == 2'd0;
	assign pop_job = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ===== rtl/fpp_back.sv =====
// fpp_back: window select, bit-serial pedestal divide and result register
// depends on fpp_pkg
module fpp_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_empty,
	input  fpp_pkg::job_t                  job,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [fpp_pkg::PED_W-1:0]      pedestal_x16,
	output logic signed [fpp_pkg::HGT_W-1:0] height_x16,
	output logic [fpp_pkg::HALF_W-1:0]     peak_half_index,
	output logic                           pulse_valid
);

	fpp_pkg::back_state_t            state_q;
	logic [fpp_pkg::CNT_W-1:0]       cnt_q;
	logic [fpp_pkg::DVD_W-1:0]       dvd_q;
	logic [fpp_pkg::K_W-1:0]         rem_q, k_q;
	logic [fpp_pkg::PAIR_W-1:0]      best_q;
	logic [fpp_pkg::HALF_W-1:0]      half_q;
	logic                            out_valid_q;

	logic [fpp_pkg::HALF_W-1:0]      half;
	logic [fpp_pkg::TIME_W-1:0]      peak_time2;
	logic [fpp_pkg::LIMIT_W-1:0]     limit2;
	logic [fpp_pkg::SUM_W-1:0]       wsum;
	logic [fpp_pkg::K_W:0]           trial, trial_sub;
	logic                            ge;
	logic [fpp_pkg::DIFF_W-1:0]      diff;
	logic                            out_free;

	// window select at job load
	assign half       = {job.best_idx, 1'b1};
	assign peak_time2 = fpp_pkg::TIME_W'(half * job.period);
	assign limit2     = {1'b0, job.ped_count, 4'd0} + fpp_pkg::LIMIT_OFS;
	assign wsum       = (peak_time2 > {8'd0, limit2}) ? job.head_sum : job.tail_sum;

	// restoring divide step, one quotient bit a cycle
	assign trial     = {rem_q, dvd_q[fpp_pkg::DVD_W-1]};
	assign ge        = trial >= {1'b0, k_q};
	assign trial_sub = trial - {1'b0, k_q};

	// quotient sits in dvd_q once the divide is done
	assign diff = {{(fpp_pkg::DIFF_W-fpp_pkg::PAIR_W-3){1'b0}}, best_q, 3'd0}
		- {1'b0, dvd_q};

	assign out_free  = !out_valid_q || !out_stall;
	assign pop       = (state_q == fpp_pkg::ST_IDLE) && !q_empty;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fpp_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result may follow the one taken in the same cycle
			if (state_q == fpp_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				fpp_pkg::ST_IDLE: begin
					if (!q_empty) begin
						cnt_q   <= fpp_pkg::CNT_W'(fpp_pkg::DVD_W - 1);
						state_q <= fpp_pkg::ST_DIV;
					end
				end
				fpp_pkg::ST_DIV: begin
					cnt_q <= cnt_q - fpp_pkg::CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= fpp_pkg::ST_DONE;
					end
				end
				fpp_pkg::ST_DONE: begin
					if (out_free) begin
						state_q <= fpp_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= fpp_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			dvd_q  <= {wsum, 4'd0};
			rem_q  <= '0;
			k_q    <= job.k;
			best_q <= job.best_sum;
			half_q <= half;
		end else if (state_q == fpp_pkg::ST_DIV) begin
			rem_q <= ge ? trial_sub[fpp_pkg::K_W-1:0] : trial[fpp_pkg::K_W-1:0];
			dvd_q <= {dvd_q[fpp_pkg::DVD_W-2:0], ge};
		end
		if (state_q == fpp_pkg::ST_DONE && out_free) begin
			pedestal_x16    <= dvd_q[fpp_pkg::PED_W-1:0];
			height_x16      <= diff[fpp_pkg::HGT_W-1:0];
			peak_half_index <= half_q;
			pulse_valid     <= !diff[fpp_pkg::DIFF_W-1];
		end
	end

endmodule

// ===== rtl/fadc_pulse_peak_and_pedestal_top.sv =====
// fadc_pulse_peak_and_pedestal_top: fadc peak finder with pedestal subtraction
// depends on fpp_pkg, fpp_front, fpp_queue, fpp_back
//
//   channel  direction  handshake              payload
//   in       to block   in_valid / in_stall    sample
//   out      from block out_valid / out_stall  pedestal_x16, height_x16,
//                                              peak_half_index, pulse_valid
//   cfg      to block   cfg_wr_en              cfg_index, cfg_data
//
// one sample is taken each cycle; the last sample of a waveform hands a job
// to a two-entry queue and stalls only while that queue is full
// the back end handles each waveform by a load, a 28-step serial divide by
// the window size and a result load; a result is offered once its job has
// passed through the queue, the load, the divide and the result load
// a held result stops the next divide, so the queue backs up
// asynchronous reset clears all control state and loads the register defaults
module fadc_pulse_peak_and_pedestal_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [fpp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fpp_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [fpp_pkg::SAMPLE_W-1:0]      sample,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [fpp_pkg::PED_W-1:0]         pedestal_x16,
	output logic signed [fpp_pkg::HGT_W-1:0]  height_x16,
	output logic [fpp_pkg::HALF_W-1:0]        peak_half_index,
	output logic                              pulse_valid
);

	// configuration registers, live for the front end
	logic [fpp_pkg::CNT_REG_W-1:0] sample_count_q;
	logic [fpp_pkg::PED_REG_W-1:0] ped_count_q;
	logic [fpp_pkg::PER_REG_W-1:0] sample_period_q;

	// queue hookup
	logic          push, pop, q_full, q_empty;
	fpp_pkg::job_t push_job, pop_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q  <= fpp_pkg::SAMPLE_COUNT_RST;
			ped_count_q     <= fpp_pkg::PED_COUNT_RST;
			sample_period_q <= fpp_pkg::SAMPLE_PER_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				fpp_pkg::REG_SAMPLE_COUNT: sample_count_q <= cfg_data;
				fpp_pkg::REG_PED_COUNT:    ped_count_q <= cfg_data[fpp_pkg::PED_REG_W-1:0];
				fpp_pkg::REG_SAMPLE_PER:   sample_period_q <= cfg_data[fpp_pkg::PER_REG_W-1:0];
				default: begin
					// unused index, write dropped
				end
			endcase
		end
	end

	// per-sample peak search and window sums
	fpp_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.sample_count     (sample_count_q),
		.ped_count        (ped_count_q),
		.sample_period_ns (sample_period_q),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.sample           (sample),
		.q_full           (q_full),
		.push             (push),
		.job              (push_job)
	);

	// finished waveforms wait here for the divider
	fpp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.full     (q_full),
		.empty    (q_empty)
	);

	// pedestal divide, height and result register
	fpp_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.job             (pop_job),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.pedestal_x16    (pedestal_x16),
		.height_x16      (height_x16),
		.peak_half_index (peak_half_index),
		.pulse_valid     (pulse_valid)
	);

endmodule

// ===== rtl/fpp_checker.sv =====
// fpp_checker: port-level checks on the result channel
// depends on fpp_pkg; bound to fadc_pulse_peak_and_pedestal_top
module fpp_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic [fpp_pkg::PED_W-1:0]         pedestal_x16,
	input  logic signed [fpp_pkg::HGT_W-1:0]  height_x16,
	input  logic [fpp_pkg::HALF_W-1:0]        peak_half_index,
	input  logic                              pulse_valid
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result does not change
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(pedestal_x16) && $stable(height_x16)
			&& $stable(peak_half_index) && $stable(pulse_valid))
		else $error("result changed while stalled");

	// peak position is a pair center, so always odd
	a_half_odd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> peak_half_index[0])
		else $error("peak half index is even");

	// pairs start at sample one, so the center is at least three half samples
	a_half_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> peak_half_index >= 11'd3)
		else $error("peak half index below first pair");

endmodule

bind fadc_pulse_peak_and_pedestal_top fpp_checker u_fpp_checker (.*);
